@@ rtl/core/mbls_pkg.sv @@
// shared constants, types and the log2 table generator for the log-log shade pipeline
package mbls_pkg;

    localparam int ITERATIONS_DEF     = 3;
    localparam int FRAC_BITS_DEF      = 28;
    localparam int LOG_TABLE_BITS_DEF = 6;

    localparam int IN_FRAC  = 28;
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 30;
    localparam int TAB_W    = LOG_FRAC + 1;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    typedef struct packed {
        logic r2_zero;
        logic hl_zero;
    } t_flags;

    // log2(1 + i/2^tb) with LOG_FRAC fraction bits, truncated; last entry is one
    function automatic logic [TAB_W-1:0] log_entry(input int tb, input int i);
        logic [63:0]      m;
        logic [TAB_W-1:0] r;
        r = '0;
        m = 64'(64'd1 << 30) + 64'(64'(i) << (30 - tb));
        if (i == (1 << tb)) begin
            r = TAB_W'(1) << LOG_FRAC;
        end else begin
            for (int b = LOG_FRAC - 1; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    r[b] = 1'b1;
                    m    = m >> 1;
                end
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mbls_mul.sv @@
// three-stage unsigned fixed-point multiplier built from four half-width partial products
module mbls_mul #(
    parameter int AW = 44,
    parameter int F  = 28,
    parameter int OW = 44
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    output logic [OW-1:0] o_p
);
    localparam int H  = (AW + 1) / 2;
    localparam int PW = 4 * H;

    logic [2*H-1:0] a_ext;
    logic [2*H-1:0] b_ext;
    logic [2*H-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [2*H-1:0] r_lo, r_hi;
    logic [2*H:0]   r_mid;
    logic [PW-1:0]  prod;
    logic [PW-1:0]  shifted;
    logic [OW-1:0]  r_p;

    assign a_ext = (2*H)'(i_a);
    assign b_ext = (2*H)'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= (2*H)'(a_ext[H-1:0] * b_ext[H-1:0]);
            r_p01 <= (2*H)'(a_ext[H-1:0] * b_ext[2*H-1:H]);
            r_p10 <= (2*H)'(a_ext[2*H-1:H] * b_ext[H-1:0]);
            r_p11 <= (2*H)'(a_ext[2*H-1:H] * b_ext[2*H-1:H]);
            r_lo  <= r_p00;
            r_hi  <= r_p11;
            r_mid <= (2*H+1)'(r_p01) + (2*H+1)'(r_p10);
            r_p   <= (shifted > PW'({OW{1'b1}})) ? {OW{1'b1}} : shifted[OW-1:0];
        end
    end

    assign prod    = {r_hi, r_lo} + (PW'(r_mid) << H);
    assign shifted = prod >> F;
    assign o_p     = r_p;

endmodule

@@ rtl/core/mbls_log.sv @@
// pipelined log2 unit: leading-one search, normalize and table lookup, interpolate
module mbls_log #(
    parameter int VW = 60,
    parameter int TB = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [VW-1:0]               i_v,
    input  mbls_pkg::t_flags            i_tag,
    output logic                        o_valid,
    output logic [mbls_pkg::LOG_W-1:0]  o_log,
    output mbls_pkg::t_flags            o_tag
);
    localparam int MSBW    = $clog2(VW);
    localparam int TAB_LEN = (1 << TB) + 1;
    localparam int RB      = 30 - TB;
    localparam int TW      = mbls_pkg::TAB_W;

    logic [TW-1:0]   tab [TAB_LEN];
    logic [MSBW-1:0] msb;
    logic [VW+29:0]  norm;
    logic [29:0]     frac;
    logic [TB-1:0]   idx;

    logic [2:0]               r_valid;
    mbls_pkg::t_flags         r_tag [3];
    logic [VW-1:0]            r_v;
    logic [MSBW-1:0]          r_msb1, r_msb2;
    logic [TW-1:0]            r_t0, r_t1;
    logic [RB-1:0]            r_rem;
    logic [mbls_pkg::LOG_W-1:0] r_log;
    logic [TW+RB-1:0]         interp;

    always_comb begin
        for (int i = 0; i < TAB_LEN; i++) begin
            tab[i] = mbls_pkg::log_entry(TB, i);
        end
    end

    always_comb begin
        msb = '0;
        for (int i = 0; i < VW; i++) begin
            if (i_v[i]) msb = MSBW'(i);
        end
    end

    // left-align the leading one, the 30 bits below it are the mantissa
    assign norm = {r_v, 30'd0} << (MSBW'(VW - 1) - r_msb1);
    assign frac = norm[VW+28 -: 30];
    assign idx  = frac[29 -: TB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
            r_v      <= i_v;
            r_msb1   <= msb;
            r_msb2   <= r_msb1;
            r_t0     <= tab[(TB+1)'(idx)];
            r_t1     <= tab[(TB+1)'(idx) + (TB+1)'(1)];
            r_rem    <= frac[RB-1:0];
            r_log    <= (mbls_pkg::LOG_W'(r_msb2) << mbls_pkg::LOG_FRAC)
                      + mbls_pkg::LOG_W'(r_t0) + mbls_pkg::LOG_W'(interp >> RB);
        end
    end

    assign interp  = (TW+RB)'((r_t1 - r_t0) * r_rem);
    assign o_valid = r_valid[2];
    assign o_log   = r_log;
    assign o_tag   = r_tag[2];

endmodule

@@ rtl/core/mbls_iter.sv @@
// one z = z*z + c step: three multipliers, then sum and symmetric saturation
module mbls_iter #(
    parameter int F = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic signed [F+16:0] i_x,
    input  logic signed [F+16:0] i_y,
    input  logic signed [F+16:0] i_ca,
    input  logic signed [F+16:0] i_cb,
    output logic              o_valid,
    output logic signed [F+16:0] o_x,
    output logic signed [F+16:0] o_y,
    output logic signed [F+16:0] o_ca,
    output logic signed [F+16:0] o_cb
);
    localparam int ZW = F + 16;
    localparam int SW = ZW + 3;
    localparam logic signed [SW-1:0] ZMAX = {3'b000, {ZW{1'b1}}};

    logic [ZW-1:0] mag_x, mag_y;
    logic [ZW-1:0] xx, yy, xy;
    logic signed [SW-1:0] nx, ny, txy;

    logic [3:0]                r_valid;
    logic signed [ZW:0]        r_ca [3];
    logic signed [ZW:0]        r_cb [3];
    logic [2:0]                r_neg;
    logic signed [ZW:0]        r_x, r_y, r_ca_o, r_cb_o;

    assign mag_x = i_x[ZW] ? ZW'(-i_x) : ZW'(i_x);
    assign mag_y = i_y[ZW] ? ZW'(-i_y) : ZW'(i_y);

    mbls_mul #(.AW(ZW), .F(F), .OW(ZW)) u_xx (
        .i_clk(i_clk), .i_en(i_en), .i_a(mag_x), .i_b(mag_x), .o_p(xx)
    );
    mbls_mul #(.AW(ZW), .F(F), .OW(ZW)) u_yy (
        .i_clk(i_clk), .i_en(i_en), .i_a(mag_y), .i_b(mag_y), .o_p(yy)
    );
    mbls_mul #(.AW(ZW), .F(F), .OW(ZW)) u_xy (
        .i_clk(i_clk), .i_en(i_en), .i_a(mag_x), .i_b(mag_y), .o_p(xy)
    );

    always_comb begin
        txy = $signed({2'b00, xy, 1'b0});
        if (r_neg[2]) txy = -txy;
        nx = $signed({3'b000, xx}) - $signed({3'b000, yy}) + SW'(r_ca[2]);
        ny = txy + SW'(r_cb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca[0] <= i_ca;
            r_cb[0] <= i_cb;
            r_neg   <= {r_neg[1:0], i_x[ZW] ^ i_y[ZW]};
            for (int i = 1; i < 3; i++) begin
                r_ca[i] <= r_ca[i-1];
                r_cb[i] <= r_cb[i-1];
            end
            if (nx > ZMAX)       r_x <= (ZW+1)'(ZMAX);
            else if (nx < -ZMAX) r_x <= (ZW+1)'(-ZMAX);
            else                 r_x <= (ZW+1)'(nx);
            if (ny > ZMAX)       r_y <= (ZW+1)'(ZMAX);
            else if (ny < -ZMAX) r_y <= (ZW+1)'(-ZMAX);
            else                 r_y <= (ZW+1)'(ny);
            r_ca_o <= r_ca[2];
            r_cb_o <= r_cb[2];
        end
    end

    assign o_valid = r_valid[3];
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ca    = r_ca_o;
    assign o_cb    = r_cb_o;

endmodule

@@ rtl/core/mandelbrot_loglog_shade.sv @@
// top level of the log-log smooth shade pipeline for one mandelbrot point per cycle when not stalled
//
// input channel: i_valid with i_real_part / i_imag_part (signed Q4.28), o_stall back.
// output channel: o_valid with o_shade (0..255), i_stall from the receiver.
// a transfer happens on a rising edge with valid high and stall low.
// a new point can enter every cycle while the output is not stalled. each point
// passes an input scaling register, then per iteration the three-stage split
// multiplier plus the add/saturate stage, the squaring multipliers for |z|^2,
// the sum register, two pipelined log2 units, an ln2 scale register after each
// log, and finally the shade register.
// throughput is one point per cycle unless stalled, set by the fully pipelined multipliers.
// a synchronous low reset clears every valid bit; no data is kept across it.
// while the output holds a result and the receiver stalls, the whole pipeline
// freezes and o_stall is raised, so nothing is lost or repeated.
module mandelbrot_loglog_shade #(
    parameter int ITERATIONS     = mbls_pkg::ITERATIONS_DEF,
    parameter int FRAC_BITS      = mbls_pkg::FRAC_BITS_DEF,
    parameter int LOG_TABLE_BITS = mbls_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_real_part,
    input  logic signed [31:0] i_imag_part,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_shade
);
    localparam int ZW = FRAC_BITS + 16;
    localparam int RW = FRAC_BITS + 32;
    localparam int LW = mbls_pkg::LOG_W;

    logic en;
    logic signed [ZW:0] ca, cb;

    logic               it_valid [ITERATIONS+1];
    logic signed [ZW:0] it_x  [ITERATIONS+1];
    logic signed [ZW:0] it_y  [ITERATIONS+1];
    logic signed [ZW:0] it_ca [ITERATIONS+1];
    logic signed [ZW:0] it_cb [ITERATIONS+1];

    logic [ZW-1:0] mag_x, mag_y;
    logic [RW-1:0] sx, sy;
    logic [RW:0]   r2_sum;
    logic [2:0]    r_sq_valid;
    logic          r_r2_valid;
    logic [RW-1:0] r_r2;
    mbls_pkg::t_flags flags_r2;

    logic             l1_valid;
    logic [LW-1:0]    l1_log;
    mbls_pkg::t_flags l1_tag;
    logic signed [31:0] l2a;
    logic [30:0]        l2a_mag;
    logic [60:0]        hl_prod;
    logic               r_hl_valid;
    logic [29:0]        r_hl;
    mbls_pkg::t_flags   r_hl_tag;
    mbls_pkg::t_flags   flags_hl;

    logic             l2_valid;
    logic [LW-1:0]    l2_log;
    mbls_pkg::t_flags l2_tag;
    logic signed [31:0] l2b;
    logic [30:0]        l2b_mag;
    logic [60:0]        g_prod;
    logic               r_g_valid;
    logic [30:0]        r_gm;
    logic               r_g_neg;
    mbls_pkg::t_flags   r_g_tag;
    logic [12:0]        ceil_v;

    logic               r_out_valid;
    logic [7:0]         r_shade;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    // bring Q4.28 into Q16.FRAC_BITS, truncating toward zero when narrowing
    generate
        if (FRAC_BITS >= mbls_pkg::IN_FRAC) begin : g_up
            assign ca = (ZW+1)'(i_real_part) <<< (FRAC_BITS - mbls_pkg::IN_FRAC);
            assign cb = (ZW+1)'(i_imag_part) <<< (FRAC_BITS - mbls_pkg::IN_FRAC);
        end else begin : g_down
            logic [31:0]        mag_re, mag_im;
            logic signed [ZW:0] ma, mb;
            assign mag_re = i_real_part[31] ? 32'(-i_real_part) : 32'(i_real_part);
            assign mag_im = i_imag_part[31] ? 32'(-i_imag_part) : 32'(i_imag_part);
            assign ma = $signed((ZW+1)'(mag_re >> (mbls_pkg::IN_FRAC - FRAC_BITS)));
            assign mb = $signed((ZW+1)'(mag_im >> (mbls_pkg::IN_FRAC - FRAC_BITS)));
            assign ca = i_real_part[31] ? -ma : ma;
            assign cb = i_imag_part[31] ? -mb : mb;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            it_valid[0] <= 1'b0;
        end else if (en) begin
            it_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            it_x[0]  <= ca;
            it_y[0]  <= cb;
            it_ca[0] <= ca;
            it_cb[0] <= cb;
        end
    end

    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
            mbls_iter #(.F(FRAC_BITS)) u_iter (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_valid(it_valid[k]), .i_x(it_x[k]), .i_y(it_y[k]),
                .i_ca(it_ca[k]), .i_cb(it_cb[k]),
                .o_valid(it_valid[k+1]), .o_x(it_x[k+1]), .o_y(it_y[k+1]),
                .o_ca(it_ca[k+1]), .o_cb(it_cb[k+1])
            );
        end
    endgenerate

    // |z|^2
    assign mag_x = it_x[ITERATIONS][ZW] ? ZW'(-it_x[ITERATIONS]) : ZW'(it_x[ITERATIONS]);
    assign mag_y = it_y[ITERATIONS][ZW] ? ZW'(-it_y[ITERATIONS]) : ZW'(it_y[ITERATIONS]);

    mbls_mul #(.AW(ZW), .F(FRAC_BITS), .OW(RW)) u_sqx (
        .i_clk(i_clk), .i_en(en), .i_a(mag_x), .i_b(mag_x), .o_p(sx)
    );
    mbls_mul #(.AW(ZW), .F(FRAC_BITS), .OW(RW)) u_sqy (
        .i_clk(i_clk), .i_en(en), .i_a(mag_y), .i_b(mag_y), .o_p(sy)
    );

    assign r2_sum = (RW+1)'(sx) + (RW+1)'(sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= '0;
            r_r2_valid  <= 1'b0;
            r_hl_valid  <= 1'b0;
            r_g_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sq_valid  <= {r_sq_valid[1:0], it_valid[ITERATIONS]};
            r_r2_valid  <= r_sq_valid[2];
            r_hl_valid  <= l1_valid;
            r_g_valid   <= l2_valid;
            r_out_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2 <= r2_sum[RW] ? {RW{1'b1}} : r2_sum[RW-1:0];
        end
    end

    assign flags_r2.r2_zero = (r_r2 == '0);
    assign flags_r2.hl_zero = 1'b0;

    mbls_log #(.VW(RW), .TB(LOG_TABLE_BITS)) u_log_r2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_r2_valid), .i_v(r_r2), .i_tag(flags_r2),
        .o_valid(l1_valid), .o_log(l1_log), .o_tag(l1_tag)
    );

    // half of |ln r2| in 24 fraction bits
    assign l2a     = $signed({2'b00, l1_log}) - 32'(FRAC_BITS << mbls_pkg::LOG_FRAC);
    assign l2a_mag = l2a[31] ? 31'(-l2a) : 31'(l2a);
    assign hl_prod = 61'(l2a_mag) * 61'(mbls_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hl     <= hl_prod[60:31];
            r_hl_tag <= l1_tag;
        end
    end

    assign flags_hl.r2_zero = r_hl_tag.r2_zero;
    assign flags_hl.hl_zero = (r_hl == '0);

    mbls_log #(.VW(30), .TB(LOG_TABLE_BITS)) u_log_hl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_hl_valid), .i_v(r_hl), .i_tag(flags_hl),
        .o_valid(l2_valid), .o_log(l2_log), .o_tag(l2_tag)
    );

    // ln of the half log, sign kept apart
    assign l2b     = $signed({2'b00, l2_log}) - 32'(mbls_pkg::LOG_FRAC << mbls_pkg::LOG_FRAC);
    assign l2b_mag = l2b[31] ? 31'(-l2b) : 31'(l2b);
    assign g_prod  = 61'(l2b_mag) * 61'(mbls_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gm    <= g_prod[60:30];
            r_g_neg <= l2b[31];
            r_g_tag <= l2_tag;
        end
    end

    // ceil(-64*g) is positive only for negative g
    assign ceil_v = 13'((32'(r_gm) + 32'((1 << 18) - 1)) >> 18);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_g_tag.r2_zero)        r_shade <= 8'd0;
            else if (r_g_tag.hl_zero)   r_shade <= 8'd255;
            else if (!r_g_neg)          r_shade <= 8'd0;
            else if (ceil_v >= 13'd255) r_shade <= 8'd255;
            else                        r_shade <= ceil_v[7:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_shade = r_shade;

    a_reset_clears : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid set right after reset");

    a_zero_r2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_g_valid && r_g_tag.r2_zero) |=> (o_valid && o_shade == 8'd0))
        else $error("zero magnitude did not give shade 0");

    a_zero_hl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_g_valid && !r_g_tag.r2_zero && r_g_tag.hl_zero)
        |=> (o_valid && o_shade == 8'd255))
        else $error("zero half log did not give shade 255");

endmodule
